// ===== rtl/ocag_pkg.sv =====
// Shared types and constants for the overlay compositor address generator.
package ocag_pkg;

  localparam int SCREEN_WIDTH_DEF  = 640;
  localparam int SCREEN_HEIGHT_DEF = 480;
  localparam int OVERLAY_COUNT_DEF = 32;
  localparam int FIFO_DEPTH        = 4;

  localparam logic [31:0] BASE_ADDRESS = 32'h0200_0000;
  // 4 bytes per pixel
  localparam int PIXEL_SHIFT = 2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] width;
    logic [15:0] height;
    logic [31:0] pointer;
  } desc_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [4:0]  slot;
    logic        is_base;
    logic        last;
  } cand_t;

endpackage

// ===== rtl/overlay_compositor_address_gen.sv =====
// Overlay compositor address generator: top level.
//
// Input stream (s_axis): one word per item. tuser selects descriptor write or
// pixel query. A write loads one descriptor slot and gives no output; writes
// can follow back to back. A query walks the descriptor memory from the
// highest slot down, one slot read per cycle through its single read port
// while the output queue has room, and emits on m_axis the source byte
// address of each enabled overlay covering the pixel, then the base
// framebuffer address with tlast and tuser set. A query holds s_axis_tready
// low until the walk has read every slot and issued the base word, and the
// read and address stages have emptied; only then is the next word taken.
// When the receiver stalls, a 4-word output queue fills and the walk pauses
// until space frees; nothing is dropped.
// Reset disables every overlay (enable bits clear at once) and empties the
// queue; no clearing pass is needed.
module overlay_compositor_address_gen #(
  parameter int SCREEN_WIDTH  = ocag_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = ocag_pkg::SCREEN_HEIGHT_DEF,
  parameter int OVERLAY_COUNT = ocag_pkg::OVERLAY_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // overlay_index[4:0], pos_x[20:5], pos_y[36:21], ov_width[52:37],
  // ov_height[68:53], src_pointer[100:69], enable[101], zero[103:102]
  input  logic [103:0] s_axis_tdata,
  // cmd[0]
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // fetch_address[31:0], source_overlay[36:32], zero[39:37]
  output logic [39:0]  m_axis_tdata,
  // is_base[0]
  output logic [0:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  localparam int AW = (OVERLAY_COUNT > 1) ? $clog2(OVERLAY_COUNT) : 1;
  localparam int CW = $clog2(ocag_pkg::FIFO_DEPTH + 1);

  logic            fire;
  logic [4:0]      in_index;
  logic [15:0]     in_x;
  logic [15:0]     in_y;
  ocag_pkg::desc_t in_desc;
  logic            in_enable;
  logic            wr_en;
  logic            start;

  logic            rd_en;
  logic [4:0]      rd_slot;
  ocag_pkg::desc_t rd_data;
  logic            rd_enabled;
  logic [CW-1:0]   fifo_count;
  logic            push;
  ocag_pkg::cand_t push_data;
  ocag_pkg::cand_t head;

  assign fire      = s_axis_tvalid && s_axis_tready;
  assign in_index  = s_axis_tdata[4:0];
  assign in_x      = s_axis_tdata[20:5];
  assign in_y      = s_axis_tdata[36:21];
  assign in_enable = s_axis_tdata[101];

  assign in_desc.x       = in_x;
  assign in_desc.y       = in_y;
  assign in_desc.width   = s_axis_tdata[52:37];
  assign in_desc.height  = s_axis_tdata[68:53];
  assign in_desc.pointer = s_axis_tdata[100:69];

  // slots past the table are dropped
  assign wr_en = fire && (s_axis_tuser[0] == ocag_pkg::CMD_WRITE) &&
                 ({1'b0, in_index} < 6'(OVERLAY_COUNT));
  assign start = fire && (s_axis_tuser[0] == ocag_pkg::CMD_QUERY);

  ocag_desc_ram #(
    .OVERLAY_COUNT(OVERLAY_COUNT)
  ) u_ram (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_addr    (in_index[AW-1:0]),
    .wr_data    (in_desc),
    .wr_enable  (in_enable),
    .rd_en      (rd_en),
    .rd_addr    (rd_slot[AW-1:0]),
    .rd_data    (rd_data),
    .rd_enabled (rd_enabled)
  );

  ocag_walk #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .OVERLAY_COUNT (OVERLAY_COUNT),
    .FIFO_DEPTH    (ocag_pkg::FIFO_DEPTH)
  ) u_walk (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .start_x    (in_x),
    .start_y    (in_y),
    .ready      (s_axis_tready),
    .rd_en      (rd_en),
    .rd_slot    (rd_slot),
    .rd_data    (rd_data),
    .rd_enabled (rd_enabled),
    .fifo_count (fifo_count),
    .push       (push),
    .push_data  (push_data)
  );

  ocag_out_fifo #(
    .DEPTH(ocag_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (m_axis_tready),
    .head      (head),
    .not_empty (m_axis_tvalid),
    .count     (fifo_count)
  );

  assign m_axis_tdata = {3'b000, head.slot, head.addr};
  assign m_axis_tuser = head.is_base;
  assign m_axis_tlast = head.last;

endmodule

// ===== rtl/ocag_desc_ram.sv =====
// Descriptor memory: one write port, one registered read port, enable bits in flops.
module ocag_desc_ram #(
  parameter int OVERLAY_COUNT = ocag_pkg::OVERLAY_COUNT_DEF,
  localparam int AW = (OVERLAY_COUNT > 1) ? $clog2(OVERLAY_COUNT) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  ocag_pkg::desc_t      wr_data,
  input  logic                 wr_enable,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output ocag_pkg::desc_t      rd_data,
  output logic                 rd_enabled
);

  ocag_pkg::desc_t            mem [OVERLAY_COUNT];
  logic [OVERLAY_COUNT-1:0]   en_bits;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data    <= mem[rd_addr];
      rd_enabled <= en_bits[rd_addr];
    end
  end

  // enable bits double as valid bits: a slot never written reads as disabled
  always_ff @(posedge clk) begin
    if (rst) begin
      en_bits <= '0;
    end else if (wr_en) begin
      en_bits[wr_addr] <= wr_enable;
    end
  end

endmodule

// ===== rtl/ocag_out_fifo.sv =====
// Small output queue holding candidate words ahead of the master port.
module ocag_out_fifo #(
  parameter int DEPTH = ocag_pkg::FIFO_DEPTH,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ocag_pkg::cand_t push_data,
  input  logic            pop,
  output ocag_pkg::cand_t head,
  output logic            not_empty,
  output logic [CW-1:0]   count
);

  ocag_pkg::cand_t mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic            do_pop;

  assign not_empty = (count != '0);
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/ocag_walk.sv =====
// Query sequencer: descending slot walk, hit test and address pipeline.
module ocag_walk #(
  parameter int SCREEN_WIDTH  = ocag_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = ocag_pkg::SCREEN_HEIGHT_DEF,
  parameter int OVERLAY_COUNT = ocag_pkg::OVERLAY_COUNT_DEF,
  parameter int FIFO_DEPTH    = ocag_pkg::FIFO_DEPTH,
  localparam int CW = $clog2(FIFO_DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [15:0]     start_x,
  input  logic [15:0]     start_y,
  output logic            ready,
  output logic            rd_en,
  output logic [4:0]      rd_slot,
  input  ocag_pkg::desc_t rd_data,
  input  logic            rd_enabled,
  input  logic [CW-1:0]   fifo_count,
  output logic            push,
  output ocag_pkg::cand_t push_data
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t      state;
  logic [5:0]  walk_slot;
  logic [15:0] qx;
  logic [15:0] qy;
  logic [31:0] base_mul;

  // read stage
  logic        t1_valid;
  logic        t1_base;
  logic [4:0]  t1_slot;

  // address stage
  logic        s2_valid;
  logic        s2_base;
  logic [4:0]  s2_slot;
  logic [31:0] s2_ptr;
  logic [15:0] s2_dx;
  logic [31:0] s2_prod;

  logic [CW:0] inflight;
  logic        issue;
  logic [16:0] x_end;
  logic [16:0] y_end;
  logic [16:0] x_lim;
  logic [16:0] y_lim;
  logic        hit_x;
  logic        hit_y;
  logic        hit;
  logic [15:0] dx;
  logic [15:0] dy;
  logic [31:0] offset;

  assign ready = (state == ST_IDLE);

  // keep queue slots reserved for every word still in the pipe
  assign inflight = {1'b0, fifo_count} + (CW + 1)'(t1_valid) + (CW + 1)'(s2_valid);
  assign issue    = (state == ST_WALK) && (inflight < (CW + 1)'(FIFO_DEPTH));

  assign rd_en   = issue && (walk_slot != '0);
  assign rd_slot = 5'(walk_slot - 6'd1);

  // span test, right and bottom edges clipped to the screen
  always_comb begin
    x_end = {1'b0, rd_data.x} + {1'b0, rd_data.width};
    y_end = {1'b0, rd_data.y} + {1'b0, rd_data.height};
    x_lim = (x_end > 17'(SCREEN_WIDTH))  ? 17'(SCREEN_WIDTH)  : x_end;
    y_lim = (y_end > 17'(SCREEN_HEIGHT)) ? 17'(SCREEN_HEIGHT) : y_end;
    hit_x = ({1'b0, rd_data.x} < x_lim) && (qx >= rd_data.x) && ({1'b0, qx} < x_lim);
    hit_y = ({1'b0, rd_data.y} < y_lim) && (qy >= rd_data.y) && ({1'b0, qy} < y_lim);
    hit   = rd_enabled && hit_x && hit_y;
    dx    = qx - rd_data.x;
    dy    = qy - rd_data.y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      walk_slot <= '0;
      t1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
    end else begin
      t1_valid <= issue;
      s2_valid <= t1_valid && (t1_base || hit);
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            walk_slot <= 6'(OVERLAY_COUNT);
            state     <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (issue) begin
            if (walk_slot != '0) begin
              walk_slot <= walk_slot - 6'd1;
            end else begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (!t1_valid && !s2_valid) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start && ready) begin
      qx <= start_x;
      qy <= start_y;
    end
    base_mul <= 32'({16'b0, qy} * 32'(SCREEN_WIDTH));
    if (issue) begin
      t1_base <= (walk_slot == '0);
      t1_slot <= rd_slot;
    end
    // base word reuses the overlay path: pointer = base, dx = px, prod = py * screen width
    if (t1_valid) begin
      s2_base <= t1_base;
      s2_slot <= t1_base ? 5'd0 : t1_slot;
      s2_ptr  <= t1_base ? ocag_pkg::BASE_ADDRESS : rd_data.pointer;
      s2_dx   <= t1_base ? qx : dx;
      s2_prod <= t1_base ? base_mul : 32'(dy * rd_data.width);
    end
  end

  assign offset = {16'b0, s2_dx} + s2_prod;

  assign push              = s2_valid;
  assign push_data.addr    = s2_ptr + (offset << ocag_pkg::PIXEL_SHIFT);
  assign push_data.slot    = s2_slot;
  assign push_data.is_base = s2_base;
  assign push_data.last    = s2_base;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking stream testbench for the overlay compositor address generator.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCR_W    = ocag_pkg::SCREEN_WIDTH_DEF;
  localparam int SCR_H    = ocag_pkg::SCREEN_HEIGHT_DEF;
  localparam int SLOTS    = ocag_pkg::OVERLAY_COUNT_DEF;
  localparam int HOLD_LEN = 400;
  localparam int LIMIT    = 400000;
  localparam int PHASE_ITEMS = 76;

  typedef struct {
    logic        cmd;
    logic [4:0]  slot;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic [31:0] ptr;
    logic        en;
  } ovl_item_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // overlay_index[4:0], pos_x[20:5], pos_y[36:21], ov_width[52:37],
  // ov_height[68:53], src_pointer[100:69], enable[101], zero[103:102]
  logic [103:0] s_axis_tdata = '0;
  // cmd[0]
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // fetch_address[31:0], source_overlay[36:32], zero[39:37]
  logic [39:0]  m_axis_tdata;
  // is_base[0]
  logic [0:0]   m_axis_tuser;
  logic         m_axis_tlast;

  overlay_compositor_address_gen dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // descriptor table as the block should hold it
  logic [15:0] ovl_x   [SLOTS] = '{default: '0};
  logic [15:0] ovl_y   [SLOTS] = '{default: '0};
  logic [15:0] ovl_w   [SLOTS] = '{default: '0};
  logic [15:0] ovl_h   [SLOTS] = '{default: '0};
  logic [31:0] ovl_ptr [SLOTS] = '{default: '0};
  logic        ovl_en  [SLOTS] = '{default: 1'b0};

  ocag_pkg::cand_t cands_due[$];
  ovl_item_t       stim_q[$];
  ovl_item_t       drv_item;

  int unsigned queued_total = 0;
  int unsigned offered = 0;
  int unsigned taken = 0;
  int          err_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_ack = 1'b0;
  int          hold_left = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // clipped span [lo, min(lo + len, limit)) contains p
  function automatic bit span_hits(logic [31:0] lo, logic [31:0] len, logic [31:0] limit,
                                   logic [31:0] p);
    logic [31:0] hi;
    hi = lo + len;
    if (hi > limit) hi = limit;
    return (lo < hi) && (p >= lo) && (p < hi);
  endfunction

  task automatic compose_candidates(input logic cmd, input logic [103:0] d);
    logic [4:0]      slot;
    logic [31:0]     px, py, dx, dy, off;
    ocag_pkg::cand_t c;
    slot = d[4:0];
    px   = d[20:5];
    py   = d[36:21];
    if (cmd == ocag_pkg::CMD_WRITE) begin
      if (slot < SLOTS) begin
        ovl_x[slot]   = d[20:5];
        ovl_y[slot]   = d[36:21];
        ovl_w[slot]   = d[52:37];
        ovl_h[slot]   = d[68:53];
        ovl_ptr[slot] = d[100:69];
        ovl_en[slot]  = d[101];
      end
    end else begin
      // highest slot first
      for (int s = SLOTS - 1; s >= 0; s--) begin
        if (ovl_en[s] && span_hits(ovl_x[s], ovl_w[s], SCR_W, px) &&
            span_hits(ovl_y[s], ovl_h[s], SCR_H, py)) begin
          dx = px - ovl_x[s];
          dy = py - ovl_y[s];
          off = (dx + dy * ovl_w[s]) << ocag_pkg::PIXEL_SHIFT;
          c.addr    = ovl_ptr[s] + off;
          c.slot    = 5'(s);
          c.is_base = 1'b0;
          c.last    = 1'b0;
          cands_due.push_back(c);
        end
      end
      off = (px + py * SCR_W) << ocag_pkg::PIXEL_SHIFT;
      c.addr    = ocag_pkg::BASE_ADDRESS + off;
      c.slot    = '0;
      c.is_base = 1'b1;
      c.last    = 1'b1;
      cands_due.push_back(c);
    end
  endtask

  function automatic ovl_item_t write_item(logic [4:0] slot, logic [15:0] x, logic [15:0] y,
                                           logic [15:0] w, logic [15:0] h, logic [31:0] ptr,
                                           logic en);
    ovl_item_t it;
    it.cmd  = ocag_pkg::CMD_WRITE;
    it.slot = slot;
    it.x    = x;
    it.y    = y;
    it.w    = w;
    it.h    = h;
    it.ptr  = ptr;
    it.en   = en;
    return it;
  endfunction

  // fields other than x and y carry junk on a query
  function automatic ovl_item_t query_item(logic [15:0] px, logic [15:0] py);
    ovl_item_t it;
    it.cmd  = ocag_pkg::CMD_QUERY;
    it.slot = 5'($urandom);
    it.x    = px;
    it.y    = py;
    it.w    = 16'($urandom);
    it.h    = 16'($urandom);
    it.ptr  = $urandom;
    it.en   = 1'($urandom);
    return it;
  endfunction

  function automatic ovl_item_t random_item();
    int r;
    r = $urandom_range(99);
    if (r < 30)
      // clustered overlays so queries stack several candidates
      return write_item(5'($urandom_range(31)), 16'(200 + $urandom_range(160)),
                        16'(150 + $urandom_range(130)), 16'(20 + $urandom_range(280)),
                        16'(20 + $urandom_range(230)), $urandom, $urandom_range(99) < 85);
    if (r < 45)
      return write_item(5'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), $urandom, 1'($urandom));
    if (r < 85)
      return query_item(16'(200 + $urandom_range(240)), 16'(150 + $urandom_range(200)));
    if (r < 93)
      return query_item(16'($urandom_range(SCR_W - 1)), 16'($urandom_range(SCR_H - 1)));
    return query_item(16'($urandom), 16'($urandom));
  endfunction

  task automatic offer(input ovl_item_t it);
    stim_q.push_back(it);
    queued_total++;
  endtask

  // every queued word taken and every candidate seen
  task automatic wait_drained();
    do @(negedge clk); while (taken != queued_total || cands_due.size() != 0);
    @(posedge clk);
  endtask

  // sender: new word only once the previous one was taken
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && offered != taken) begin
      s_axis_tvalid <= 1'b1;
    end else if (stim_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      drv_item = stim_q.pop_front();
      s_axis_tdata  <= {2'b00, drv_item.en, drv_item.ptr, drv_item.h, drv_item.w,
                        drv_item.y, drv_item.x, drv_item.slot};
      s_axis_tuser  <= drv_item.cmd;
      s_axis_tvalid <= 1'b1;
      offered       <= offered + 1;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // receiver, with a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack      <= hold_req;
      hold_left     <= HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    ocag_pkg::cand_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        compose_candidates(s_axis_tuser[0], s_axis_tdata);
        taken <= taken + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (cands_due.size() == 0) begin
          $error("unexpected word: fetch_address %h source_overlay %0d",
                 m_axis_tdata[31:0], m_axis_tdata[36:32]);
          err_count++;
        end else begin
          want = cands_due.pop_front();
          if (m_axis_tdata[31:0] !== want.addr) begin
            $error("fetch_address: expected %h, actual %h", want.addr, m_axis_tdata[31:0]);
            err_count++;
          end
          if (m_axis_tdata[36:32] !== want.slot) begin
            $error("source_overlay: expected %0d, actual %0d", want.slot,
                   m_axis_tdata[36:32]);
            err_count++;
          end
          if (m_axis_tuser[0] !== want.is_base) begin
            $error("is_base: expected %b, actual %b", want.is_base, m_axis_tuser[0]);
            err_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last: expected %b, actual %b", want.last, m_axis_tlast);
            err_count++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    int cyc;
    for (cyc = 0; cyc < LIMIT; cyc++) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int p;
    int k;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, full-screen overlay, clipping, edges, off-screen
    offer(query_item(16'd0, 16'd0));
    offer(query_item(16'd639, 16'd479));
    offer(query_item(16'hFFFF, 16'hFFFF));
    offer(write_item(5'd31, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFC, 1'b1));
    offer(query_item(16'd639, 16'd479));
    offer(query_item(16'd640, 16'd0));
    offer(write_item(5'd0, 16'd100, 16'd50, 16'd10, 16'd10, 32'h0000_1000, 1'b1));
    offer(query_item(16'd105, 16'd55));
    offer(query_item(16'd109, 16'd59));
    offer(query_item(16'd110, 16'd60));
    offer(write_item(5'd5, 16'd100, 16'd50, 16'd10, 16'd10, 32'h1234_5678, 1'b0));
    offer(write_item(5'd7, 16'd100, 16'd50, 16'd0, 16'd10, 32'h2000_0000, 1'b1));
    offer(write_item(5'd8, 16'd100, 16'd50, 16'd10, 16'd0, 32'h3000_0000, 1'b1));
    offer(write_item(5'd9, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0, 1'b1));
    offer(write_item(5'd10, 16'd630, 16'd470, 16'hFFFF, 16'hFFFF, 32'hAAAA_5555, 1'b1));
    offer(query_item(16'd100, 16'd50));
    offer(query_item(16'd635, 16'd475));
    offer(query_item(16'd639, 16'd479));
    offer(write_item(5'd31, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     $urandom, 1'b0));
    offer(query_item(16'd105, 16'd55));
    offer(query_item(16'd0, 16'd479));
    offer(write_item(5'd3, 16'd0, 16'd0, 16'd1, 16'd1, 32'h8000_0000, 1'b1));
    offer(query_item(16'd0, 16'd0));
    wait_drained();

    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) offer(random_item());
      wait_drained();
    end

    // every slot covers all queried pixels, so each query gives the full candidate set;
    // the receiver holds off long enough for the output queue to back up
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (k = 0; k < SLOTS; k++)
      offer(write_item(5'(k), 16'($urandom_range(10)), 16'($urandom_range(10)),
                       16'(SCR_W + $urandom_range(1000)), 16'(SCR_H + $urandom_range(1000)),
                       $urandom, 1'b1));
    for (k = 0; k < 10; k++)
      offer(query_item(16'(10 + $urandom_range(SCR_W - 11)),
                       16'(10 + $urandom_range(SCR_H - 11))));
    hold_req = ~hold_req;
    wait_drained();

    repeat (50) @(posedge clk);
    if (err_count == 0 && cands_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== overlay_compositor_address_gen.f =====
rtl/ocag_pkg.sv
rtl/ocag_desc_ram.sv
rtl/ocag_out_fifo.sv
rtl/ocag_walk.sv
rtl/overlay_compositor_address_gen.sv
tb/sv/tb_top.sv
